/* design/pidcs_pkg.sv */
// Shared types, constants and helpers for the PID controller with clamp and slew limit.
package pidcs_pkg;

   localparam int FRAC_BITS = 16;

   localparam int DATA_W  = 32;               // error, gains, output
   localparam int DT_W    = 31;               // time_step, output_limit, slew_limit
   localparam int OPND_W  = 33;               // shared multiplier operand width
   localparam int PROD_W  = 2 * OPND_W;       // shared multiplier product width
   localparam int MAG_W   = 63;               // magnitude bound of the derivative product
   localparam int CNT_W   = $clog2(DT_W + 1);
   localparam int LIM_W   = 2 * DT_W - FRAC_BITS; // slew step per sample
   localparam int INDEX_W = 3;

   localparam logic [INDEX_W-1:0] REG_PROP_GAIN    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_INTEG_GAIN   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_DERIV_GAIN   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_TIME_STEP    = 3'd3;
   localparam logic [INDEX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;
   localparam logic [INDEX_W-1:0] REG_SLEW_LIMIT   = 3'd5;

   localparam logic signed [DATA_W-1:0] PROP_GAIN_RESET    = DATA_W'(20 * (2 ** FRAC_BITS));
   localparam logic [DT_W-1:0]          TIME_STEP_RESET    = DT_W'(5 * (2 ** FRAC_BITS));
   localparam logic [DT_W-1:0]          OUTPUT_LIMIT_RESET = DT_W'(15 * (2 ** FRAC_BITS));
   localparam logic [DT_W-1:0]          SLEW_LIMIT_RESET   = DT_W'((21 * (2 ** FRAC_BITS)) / 2);

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quotient;
   } div_sts_type;

   // saturate a wide signed value to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(S32_MAX);
      lo = PROD_W'(S32_MIN);
      if (v > hi) begin
         return S32_MAX;
      end else if (v < lo) begin
         return S32_MIN;
      end else begin
         return v[DATA_W-1:0];
      end
   endfunction

endpackage

/* design/pidcs_mul.sv */
// Shared signed multiplier with a registered product.
module pidcs_mul import pidcs_pkg::*; (
   input  logic                     clock,
   input  logic signed [OPND_W-1:0] op_a,
   input  logic signed [OPND_W-1:0] op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* design/pidcs_div.sv */
// Restoring divider, one quotient bit a cycle, signed dividend truncated toward zero, sat32.
module pidcs_div import pidcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [PROD_W-1:0] dividend,
   input  logic [DT_W-1:0]          divisor,
   output div_sts_type              sts
);

   typedef enum logic [3:0] {
      DV_IDLE  = 4'b0001,
      DV_CHECK = 4'b0010,
      DV_RUN   = 4'b0100,
      DV_FIN   = 4'b1000
   } dv_state_type;

   dv_state_type dv_state_ff, dv_state_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic             ovf_ff, ovf_in;
   logic [DT_W-1:0]  rem_ff, rem_in;
   logic [DT_W-1:0]  num_ff, num_in;
   logic [DT_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [PROD_W-1:0] neg_dividend;
   logic [DT_W:0]            high;
   logic [DT_W:0]            trial;
   logic [DT_W:0]            trial_sub;
   logic signed [DATA_W-1:0] quo_signed;

   assign neg_dividend = -dividend;
   assign high         = mag_ff[MAG_W-1:MAG_W-DT_W-1];
   assign trial        = {rem_ff, num_ff[DT_W-1]};
   assign trial_sub    = trial - {1'b0, divisor};
   assign quo_signed   = {1'b0, quo_ff};

   always_comb begin
      dv_state_in = dv_state_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      ovf_in      = ovf_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      case (dv_state_ff)
         DV_IDLE: begin
            if (start) begin
               mag_in      = dividend[PROD_W-1] ? neg_dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
               neg_in      = dividend[PROD_W-1];
               dv_state_in = DV_CHECK;
            end
         end
         DV_CHECK: begin
            // quotient reaches 2^31 exactly when the top bits already hold the divisor
            ovf_in      = (high >= {1'b0, divisor});
            rem_in      = high[DT_W-1:0];
            num_in      = mag_ff[DT_W-1:0];
            quo_in      = '0;
            cnt_in      = CNT_W'(DT_W);
            dv_state_in = ovf_in ? DV_FIN : DV_RUN;
         end
         DV_RUN: begin
            if (trial >= {1'b0, divisor}) begin
               rem_in = trial_sub[DT_W-1:0];
               quo_in = {quo_ff[DT_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DT_W-1:0];
               quo_in = {quo_ff[DT_W-2:0], 1'b0};
            end
            num_in = {num_ff[DT_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               dv_state_in = DV_FIN;
            end
         end
         DV_FIN: begin
            dv_state_in = DV_IDLE;
         end
         default: begin
            dv_state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_state_ff <= DV_IDLE;
      end else begin
         dv_state_ff <= dv_state_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      sts.done = (dv_state_ff == DV_FIN);
      if (ovf_ff) begin
         sts.quotient = neg_ff ? S32_MIN : S32_MAX;
      end else begin
         sts.quotient = neg_ff ? -quo_signed : quo_signed;
      end
   end

endmodule

/* design/pid_with_clamp_and_slew_limit.sv */
// Top level: PID controller with symmetric output clamp and slew-rate limit.
//
// Input channel (req_): one error sample per item, signed Q16.16. Result channel
// (rsp_): drive value plus clamp and slew flags, one result per item. Both sides
// use valid/stall; an item moves on a clock edge with valid high and stall low.
// csr_ is a plain write port: csr_write, csr_index (register number), csr_data.
// Write registers only while the block is idle.
//
// Sequence: an item is taken in idle, then one shared 33x33 multiplier runs five
// products in turn (e*dt, kp*e, ki*I, kd*de, slew*dt) and a bit-serial divider
// forms kd*de/dt, 31 quotient bits at one bit a cycle. The divider sets the
// pace: req_stall is high while an item is in progress, and a new item is
// taken only once the previous one has reached the result register.
// The result register lets the next item start while a result is still held;
// a held result under rsp_stall only blocks the finish of the following item.
//
// Reset (synchronous, active high) restores default gains and limits, clears
// the integral, previous error and previous output, and empties the result.
module pid_with_clamp_and_slew_limit import pidcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_error_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_drive_value,
   output logic                     rsp_was_clamped,
   output logic                     rsp_was_slew_limited,
   input  logic                     csr_write,
   input  logic [INDEX_W-1:0]       csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_M_EDT = 10'b0000000010,
      S_M_KP  = 10'b0000000100,
      S_M_KI  = 10'b0000001000,
      S_M_KD  = 10'b0000010000,
      S_M_SL  = 10'b0000100000,
      S_LIM   = 10'b0001000000,
      S_DIV   = 10'b0010000000,
      S_SUM   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   // configuration
   logic signed [DATA_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [DT_W-1:0]          dt_cfg_ff, olim_ff, slew_ff;

   // sequencer and datapath registers
   state_type                state_ff, state_in;
   logic signed [DATA_W-1:0] e_ff, e_in;
   logic signed [DATA_W-1:0] integ_ff, integ_in;
   logic signed [DATA_W-1:0] last_err_ff, last_err_in;
   logic signed [DATA_W-1:0] last_out_ff, last_out_in;
   logic signed [DATA_W-1:0] up_ff, up_in;
   logic signed [DATA_W-1:0] ui_ff, ui_in;
   logic signed [DATA_W-1:0] ud_ff, ud_in;
   logic [LIM_W-1:0]         lim_ff, lim_in;
   logic signed [DATA_W-1:0] u_ff, u_in;
   logic                     clamped_ff, clamped_in;
   logic signed [DATA_W:0]   delta_ff, delta_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                     rsp_clamp_ff, rsp_clamp_in;
   logic                     rsp_slew_ff, rsp_slew_in;

   // shared units
   logic signed [OPND_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   logic                     div_start;
   div_sts_type              div_sts;

   logic [DT_W-1:0]          dt;
   logic signed [PROD_W-1:0] prod_shr;
   logic signed [PROD_W-1:0] integ_wide;
   logic signed [DATA_W:0]   diff;
   logic signed [DATA_W+1:0] sum;
   logic signed [DATA_W+1:0] olim_wide;
   logic [DATA_W:0]          mag;
   logic                     slew_hit;
   logic signed [DATA_W+1:0] last_out_wide;
   logic signed [DATA_W+1:0] step_wide;
   logic signed [DATA_W+1:0] slewed;
   logic signed [DATA_W-1:0] final_u;

   // zero time step counts as the smallest step
   assign dt = (dt_cfg_ff == '0) ? DT_W'(1) : dt_cfg_ff;

   pidcs_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   pidcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_prod),
      .divisor  (dt),
      .sts      (div_sts)
   );

   // floor shift of the product back to Q16.16
   assign prod_shr   = mul_prod >>> FRAC_BITS;
   assign integ_wide = {{(PROD_W-DATA_W){integ_ff[DATA_W-1]}}, integ_ff};
   assign diff       = {e_ff[DATA_W-1], e_ff} - {last_err_ff[DATA_W-1], last_err_ff};

   // exact sum of the three terms, then symmetric clamp
   assign sum       = {{2{up_ff[DATA_W-1]}}, up_ff} + {{2{ui_ff[DATA_W-1]}}, ui_ff}
                    + {{2{ud_ff[DATA_W-1]}}, ud_ff};
   assign olim_wide = {3'b000, olim_ff};

   // slew limit against the previous output
   assign mag           = delta_ff[DATA_W] ? -delta_ff : delta_ff;
   assign slew_hit      = (LIM_W'(mag) > lim_ff);
   assign last_out_wide = {{2{last_out_ff[DATA_W-1]}}, last_out_ff};
   assign step_wide     = {1'b0, lim_ff[DATA_W:0]};
   assign slewed        = delta_ff[DATA_W] ? last_out_wide - step_wide
                                           : last_out_wide + step_wide;
   assign final_u       = slew_hit ? slewed[DATA_W-1:0] : u_ff;

   always_comb begin
      state_in     = state_ff;
      e_in         = e_ff;
      integ_in     = integ_ff;
      last_err_in  = last_err_ff;
      last_out_in  = last_out_ff;
      up_in        = up_ff;
      ui_in        = ui_ff;
      ud_in        = ud_ff;
      lim_in       = lim_ff;
      u_in         = u_ff;
      clamped_in   = clamped_ff;
      delta_in     = delta_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_drive_in = rsp_drive_ff;
      rsp_clamp_in = rsp_clamp_ff;
      rsp_slew_in  = rsp_slew_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               e_in     = req_error_sample;
               state_in = S_M_EDT;
            end
         end
         S_M_EDT: begin
            mul_a    = {e_ff[DATA_W-1], e_ff};
            mul_b    = {2'b00, dt};
            state_in = S_M_KP;
         end
         S_M_KP: begin
            // product is e*dt
            integ_in = sat32(integ_wide + prod_shr);
            mul_a    = {kp_ff[DATA_W-1], kp_ff};
            mul_b    = {e_ff[DATA_W-1], e_ff};
            state_in = S_M_KI;
         end
         S_M_KI: begin
            // product is kp*e; integral already updated
            up_in    = sat32(prod_shr);
            mul_a    = {ki_ff[DATA_W-1], ki_ff};
            mul_b    = {integ_ff[DATA_W-1], integ_ff};
            state_in = S_M_KD;
         end
         S_M_KD: begin
            ui_in    = sat32(prod_shr);
            mul_a    = {kd_ff[DATA_W-1], kd_ff};
            mul_b    = diff;
            state_in = S_M_SL;
         end
         S_M_SL: begin
            // product is kd*(e - last error): hand it to the divider
            div_start = 1'b1;
            mul_a     = {2'b00, slew_ff};
            mul_b     = {2'b00, dt};
            state_in  = S_LIM;
         end
         S_LIM: begin
            lim_in   = mul_prod[2*DT_W-1:FRAC_BITS];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_sts.done) begin
               ud_in    = div_sts.quotient;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (sum > olim_wide) begin
               u_in       = olim_wide[DATA_W-1:0];
               clamped_in = 1'b1;
            end else if (sum < -olim_wide) begin
               u_in       = -olim_wide[DATA_W-1:0];
               clamped_in = 1'b1;
            end else begin
               u_in       = sum[DATA_W-1:0];
               clamped_in = 1'b0;
            end
            delta_in = {u_in[DATA_W-1], u_in} - {last_out_ff[DATA_W-1], last_out_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = final_u;
               rsp_clamp_in = clamped_ff;
               rsp_slew_in  = slew_hit;
               last_err_in  = e_ff;
               last_out_in  = final_u;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_err_ff  <= '0;
         last_out_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_err_ff  <= last_err_in;
         last_out_ff  <= last_out_in;
      end
      e_ff         <= e_in;
      up_ff        <= up_in;
      ui_ff        <= ui_in;
      ud_ff        <= ud_in;
      lim_ff       <= lim_in;
      u_ff         <= u_in;
      clamped_ff   <= clamped_in;
      delta_ff     <= delta_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_clamp_ff <= rsp_clamp_in;
      rsp_slew_ff  <= rsp_slew_in;
   end

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= PROP_GAIN_RESET;
         ki_ff     <= '0;
         kd_ff     <= '0;
         dt_cfg_ff <= TIME_STEP_RESET;
         olim_ff   <= OUTPUT_LIMIT_RESET;
         slew_ff   <= SLEW_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PROP_GAIN:    kp_ff     <= csr_data;
            REG_INTEG_GAIN:   ki_ff     <= csr_data;
            REG_DERIV_GAIN:   kd_ff     <= csr_data;
            REG_TIME_STEP:    dt_cfg_ff <= csr_data[DT_W-1:0];
            REG_OUTPUT_LIMIT: olim_ff   <= csr_data[DT_W-1:0];
            REG_SLEW_LIMIT:   slew_ff   <= csr_data[DT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_value      = rsp_drive_ff;
   assign rsp_was_clamped      = rsp_clamp_ff;
   assign rsp_was_slew_limited = rsp_slew_ff;

endmodule

/* bench/tb_pid_with_clamp_and_slew_limit.sv */
// Self-checking bench for the PID controller with symmetric clamp and slew limit.
`timescale 1ns / 100ps

module tb_pid_with_clamp_and_slew_limit;
   import pidcs_pkg::*;

   // Register numbers the block does not decode; writes there must be dropped.
   localparam logic [INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh0001_0000;   // 1.0 in Q16.16
   localparam logic [DT_W-1:0]          DT_MAX = 31'h7fff_ffff;

   typedef enum {CFG_TYPICAL, CFG_FINE_STEP, CFG_WIDE_OPEN, CFG_FULL_RANGE} cfg_style_type;

   typedef struct {
      logic signed [DATA_W-1:0] drive;
      logic                     clamped;
      logic                     slewed;
   } drive_result_type;

   // DUT ports; every input is known from time zero.
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_error_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_drive_value;
   logic                     rsp_was_clamped;
   logic                     rsp_was_slew_limited;
   logic                     csr_write = 1'b0;
   logic [INDEX_W-1:0]       csr_index = '0;
   logic [DATA_W-1:0]        csr_data = '0;

   // Controller image: register copies and loop state.
   logic signed [DATA_W-1:0] cfg_prop_gain  = PROP_GAIN_RESET;
   logic signed [DATA_W-1:0] cfg_integ_gain = '0;
   logic signed [DATA_W-1:0] cfg_deriv_gain = '0;
   logic [DT_W-1:0]          cfg_time_step  = TIME_STEP_RESET;
   logic [DT_W-1:0]          cfg_out_limit  = OUTPUT_LIMIT_RESET;
   logic [DT_W-1:0]          cfg_slew_limit = SLEW_LIMIT_RESET;
   longint                   integ_acc  = 0;
   longint                   prev_error = 0;
   longint                   prev_drive = 0;

   drive_result_type expected_drives[$];
   int               mismatch_count = 0;

   // Traffic shaping knobs.
   bit gaps_on  = 1'b1;     // sender bursts with gaps
   bit stall_on = 1'b1;     // receiver stall pattern
   int burst_left = 0;
   int hold_cycles = 0;     // long receiver hold-off, counted down by the receiver
   bit run_stall = 1'b0;
   int run_left = 0;
   logic signed [DATA_W-1:0] walk_error = '0;

   pid_with_clamp_and_slew_limit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_error_sample     (req_error_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drive_value      (rsp_drive_value),
      .rsp_was_clamped      (rsp_was_clamped),
      .rsp_was_slew_limited (rsp_was_slew_limited),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic longint clip_s32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // One control step: updates the loop state and returns the drive item.
   function automatic drive_result_type predict_drive(input logic signed [DATA_W-1:0] e);
      longint           ev, dt, kp, ki, kd, up, ui, ud, u, olim, slim, step_lim, delta, mag;
      drive_result_type r;
      ev = e;
      kp = cfg_prop_gain;
      ki = cfg_integ_gain;
      kd = cfg_deriv_gain;
      dt = cfg_time_step;
      if (dt == 0) begin
         dt = 1;                          // zero step behaves as the smallest step
      end
      olim = cfg_out_limit;
      slim = cfg_slew_limit;
      r.clamped = 1'b0;
      r.slewed  = 1'b0;

      // integral first, the ki term uses the updated value
      integ_acc = clip_s32(integ_acc + ((ev * dt) >>> FRAC_BITS));
      up = clip_s32((kp * ev) >>> FRAC_BITS);
      ui = clip_s32((ki * integ_acc) >>> FRAC_BITS);
      ud = clip_s32((kd * (ev - prev_error)) / dt);   // truncates toward zero
      prev_error = ev;

      u = up + ui + ud;
      if (u > olim) begin
         u = olim;
         r.clamped = 1'b1;
      end else if (u < -olim) begin
         u = -olim;
         r.clamped = 1'b1;
      end

      step_lim = (slim * dt) >>> FRAC_BITS;
      delta = u - prev_drive;
      mag = (delta < 0) ? -delta : delta;
      if (mag > step_lim) begin
         u = (delta > 0) ? prev_drive + step_lim : prev_drive - step_lim;
         r.slewed = 1'b1;
      end
      prev_drive = u;
      r.drive = u[DATA_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic int rand_span(input int unsigned r);
      return int'($urandom_range(0, 2 * r)) - int'(r);
   endfunction

   // Register write; the image follows at once since the block is idle.
   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         REG_PROP_GAIN:    cfg_prop_gain  = data;
         REG_INTEG_GAIN:   cfg_integ_gain = data;
         REG_DERIV_GAIN:   cfg_deriv_gain = data;
         REG_TIME_STEP:    cfg_time_step  = data[DT_W-1:0];
         REG_OUTPUT_LIMIT: cfg_out_limit  = data[DT_W-1:0];
         REG_SLEW_LIMIT:   cfg_slew_limit = data[DT_W-1:0];
         default: ;                       // undecoded index, nothing changes
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Send one error item; bursts of random length with random gaps in between.
   task automatic send_error(input logic signed [DATA_W-1:0] e);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = gaps_on ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_error_sample <= e;
      do @(posedge clock); while (req_stall);
      expected_drives.push_back(predict_drive(e));
   endtask

   // Drop valid and wait until every item has come back; the block is then idle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Error stream: mostly a random walk like a real loop, plus spread, corner values and noise.
   function automatic logic signed [DATA_W-1:0] pick_error();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         return $urandom;                  // full 32-bit noise, every bit toggles
      end else if (sel < 15) begin
         case ($urandom_range(0, 4))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return '0;
            3: return -1;
            default: return 1;
         endcase
      end else if (sel < 40) begin
         return rand_span(100 << FRAC_BITS);
      end
      walk_error = walk_error + rand_span(ONE_Q);
      if (walk_error > (1000 << FRAC_BITS) || walk_error < -(1000 << FRAC_BITS)) begin
         walk_error = '0;
      end
      return walk_error;
   endfunction

   task automatic apply_style(input cfg_style_type style);
      case (style)
         CFG_TYPICAL: begin
            write_reg(REG_PROP_GAIN,    rand_span(8 << FRAC_BITS));
            write_reg(REG_INTEG_GAIN,   rand_span(2 << FRAC_BITS));
            write_reg(REG_DERIV_GAIN,   rand_span(2 << FRAC_BITS));
            write_reg(REG_TIME_STEP,    $urandom_range(3277, 10 << FRAC_BITS));
            write_reg(REG_OUTPUT_LIMIT, $urandom_range(ONE_Q, 500 << FRAC_BITS));
            write_reg(REG_SLEW_LIMIT,   $urandom_range(6554, 100 << FRAC_BITS));
         end
         CFG_FINE_STEP: begin
            // tiny dt: large derivative quotients, small slew steps
            write_reg(REG_PROP_GAIN,    rand_span(4 << FRAC_BITS));
            write_reg(REG_INTEG_GAIN,   rand_span(16 << FRAC_BITS));
            write_reg(REG_DERIV_GAIN,   rand_span(ONE_Q / 2));
            write_reg(REG_TIME_STEP,    $urandom_range(1, 1000));
            write_reg(REG_OUTPUT_LIMIT, $urandom_range(ONE_Q, 1000 << FRAC_BITS));
            write_reg(REG_SLEW_LIMIT,   $urandom_range(ONE_Q, DT_MAX));
         end
         CFG_WIDE_OPEN: begin
            // limits out of the way, raw sum visible
            write_reg(REG_PROP_GAIN,    rand_span(ONE_Q));
            write_reg(REG_INTEG_GAIN,   rand_span(ONE_Q / 4));
            write_reg(REG_DERIV_GAIN,   rand_span(ONE_Q));
            write_reg(REG_TIME_STEP,    $urandom_range(ONE_Q / 16, 2 << FRAC_BITS));
            write_reg(REG_OUTPUT_LIMIT, {1'b0, DT_MAX});
            write_reg(REG_SLEW_LIMIT,   {1'b0, DT_MAX});
         end
         default: begin
            write_reg(REG_PROP_GAIN,    $urandom);
            write_reg(REG_INTEG_GAIN,   $urandom);
            write_reg(REG_DERIV_GAIN,   $urandom);
            write_reg(REG_TIME_STEP,    $urandom_range(1, DT_MAX));
            write_reg(REG_OUTPUT_LIMIT, $urandom_range(0, DT_MAX));
            write_reg(REG_SLEW_LIMIT,   $urandom_range(0, DT_MAX));
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: kp 20, dt 5, limit 15, slew 10.5 per time unit.
   task automatic test_reset_defaults();
      send_error('0);
      send_error(ONE_Q);
      send_error(-ONE_Q);
      send_error(S32_MAX);
      send_error(S32_MIN);
      drain();
   endtask

   // Gain and step extremes, saturation of every term and of the integral.
   task automatic test_gain_extremes();
      write_reg(REG_PROP_GAIN,    S32_MAX);
      write_reg(REG_INTEG_GAIN,   S32_MIN);
      write_reg(REG_DERIV_GAIN,   S32_MAX);
      write_reg(REG_TIME_STEP,    32'd1);
      write_reg(REG_OUTPUT_LIMIT, {1'b0, DT_MAX});
      write_reg(REG_SLEW_LIMIT,   {1'b0, DT_MAX});
      send_error(S32_MAX);
      send_error(S32_MIN);
      send_error('0);
      drain();
      write_reg(REG_PROP_GAIN,  S32_MIN);
      write_reg(REG_INTEG_GAIN, S32_MAX);
      write_reg(REG_DERIV_GAIN, S32_MIN);
      send_error(S32_MIN);
      send_error(S32_MAX);
      drain();
      // zero time step acts as one LSB
      write_reg(REG_TIME_STEP, '0);
      send_error(32'sd1);
      send_error(-32'sd1);
      drain();
      // longest step drives the integral into saturation
      write_reg(REG_TIME_STEP, {1'b0, DT_MAX});
      send_error(S32_MAX);
      send_error(S32_MIN);
      drain();
   endtask

   // Zero output limit, zero slew limit, and writes to undecoded indexes.
   task automatic test_zero_limits();
      write_reg(REG_PROP_GAIN,    ONE_Q);
      write_reg(REG_INTEG_GAIN,   '0);
      write_reg(REG_DERIV_GAIN,   '0);
      write_reg(REG_TIME_STEP,    ONE_Q);
      write_reg(REG_OUTPUT_LIMIT, '0);
      send_error(ONE_Q);
      send_error('0);
      drain();
      write_reg(REG_OUTPUT_LIMIT, {1'b0, OUTPUT_LIMIT_RESET});
      write_reg(REG_SLEW_LIMIT,   '0);
      send_error(3 * ONE_Q);
      send_error(-3 * ONE_Q);
      drain();
      write_reg(REG_SLEW_LIMIT, 5 * ONE_Q);
      write_reg(REG_SPARE_LO, '1);
      write_reg(REG_SPARE_HI, '0);
      send_error(2 * ONE_Q);
      send_error(-2 * ONE_Q);
      drain();
   endtask

   // Phases of random traffic, each under its own register setting.
   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         apply_style(cfg_style_type'(phase % 4));
         // some phases run with one or both sides never idling
         gaps_on  = !(phase == 2 || phase == 6);
         stall_on = !(phase == 5 || phase == 6);
         walk_error = '0;
         for (int n = 0; n < 75; n++) begin
            send_error(pick_error());
         end
         drain();
      end
      gaps_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   // Receiver holds off long enough that the block backs up into its input.
   task automatic test_output_backpressure();
      apply_style(CFG_TYPICAL);
      gaps_on = 1'b0;
      hold_cycles = 400;
      for (int n = 0; n < 12; n++) begin
         send_error(pick_error());
      end
      drain();
      gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Receiver: stall runs of random length, or a long hold-off on request.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (!stall_on) begin
         rsp_stall <= 1'b0;
      end else begin
         if (run_left == 0) begin
            run_stall = !run_stall;
            run_left  = run_stall ? $urandom_range(1, 6) : $urandom_range(1, 10);
         end
         run_left--;
         rsp_stall <= run_stall;
      end
   end

   // ------------------------------------------------------------------
   // Result check: each accepted item against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drives.size() == 0) begin
            $error("result item with none expected: drive_value %0d", rsp_drive_value);
            mismatch_count++;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_drive_value !== want.drive) begin
               $error("drive_value expected %0d got %0d", want.drive, rsp_drive_value);
               mismatch_count++;
            end
            if (rsp_was_clamped !== want.clamped) begin
               $error("was_clamped expected %0b got %0b", want.clamped, rsp_was_clamped);
               mismatch_count++;
            end
            if (rsp_was_slew_limited !== want.slewed) begin
               $error("was_slew_limited expected %0b got %0b",
                      want.slewed, rsp_was_slew_limited);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_gain_extremes();
      test_zero_limits();
      test_random_phases();
      test_output_backpressure();

      // everything returned; give the pipeline its latency once more
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_pid_with_clamp_and_slew_limit: clean");
      end else begin
         $display("tb_pid_with_clamp_and_slew_limit: errors");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb_pid_with_clamp_and_slew_limit: errors");
      $finish;
   end

endmodule

/* sim.f */
design/pidcs_pkg.sv
design/pidcs_mul.sv
design/pidcs_div.sv
design/pid_with_clamp_and_slew_limit.sv
bench/tb_pid_with_clamp_and_slew_limit.sv
